// File: rtl/tclp_pkg.sv
// Shared types, constants and word tables of the text command line parser.
package tclp_pkg;

  // Default line length in bytes; one byte less is kept before the line is dropped.
  localparam int unsigned LineBytesDef = 20;

  // Depth of the queue between the byte classifier and the line interpreter.
  localparam int unsigned QueueDepth = 2;

  // Widths of the data byte, the level, the command code and the configuration index.
  localparam int unsigned ByteW  = 8;
  localparam int unsigned LevelW = 16;
  localparam int unsigned CodeW  = 3;
  localparam int unsigned CfgIdxW = 2;

  // The pwm argument is held saturated at one above the limit.
  localparam int unsigned PwmLimit = 2000;
  localparam int unsigned ArgW     = 11;
  localparam int unsigned ProdW    = 15;

  // Number of command words and the width of the word position counter.
  localparam int unsigned NumCmds = 7;
  localparam int unsigned WordPosW = 3;

  // Characters with a meaning of their own.
  localparam logic [ByteW-1:0] ChCr    = 8'h0d;
  localparam logic [ByteW-1:0] ChLf    = 8'h0a;
  localparam logic [ByteW-1:0] ChSpace = 8'h20;
  localparam logic [ByteW-1:0] ChNul   = 8'h00;
  localparam logic [ByteW-1:0] ChZero  = 8'h30;
  localparam logic [ByteW-1:0] ChNine  = 8'h39;
  localparam logic [ByteW-1:0] ChUpA   = 8'h41;
  localparam logic [ByteW-1:0] ChUpZ   = 8'h5a;
  localparam logic [ByteW-1:0] CaseBit = 8'h20;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgLowLevel  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMidLevel  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgHighLevel = 2'd2;

  // Reset values of the level registers.
  localparam logic [LevelW-1:0] LowLevelRst  = 16'd500;
  localparam logic [LevelW-1:0] MidLevelRst  = 16'd1000;
  localparam logic [LevelW-1:0] HighLevelRst = 16'd2000;

  // Command codes reported with each result.
  typedef enum logic [CodeW-1:0] {
    CmdNone = 3'd0,
    CmdOn   = 3'd1,
    CmdOff  = 3'd2,
    CmdLow  = 3'd3,
    CmdMid  = 3'd4,
    CmdHigh = 3'd5,
    CmdPwm  = 3'd6,
    CmdAuto = 3'd7
  } cmd_e;

  // Kind of beat handed from the classifier to the interpreter.
  typedef enum logic {
    OpChar = 1'b0,
    OpEnd  = 1'b1
  } op_e;

  // Where the interpreter stands within the current line.
  typedef enum logic [1:0] {
    PhWord   = 2'd0,
    PhSpaces = 2'd1,
    PhArg    = 2'd2
  } phase_e;

  // One queued beat.
  typedef struct packed {
    op_e              op;
    logic [ByteW-1:0] data;
  } q_item_t;

  // Length of command word k (k counts from zero, in code order).
  function automatic logic [WordPosW-1:0] cmd_len(input logic [CodeW-1:0] k);
    logic [WordPosW-1:0] len;
    len = 3'd3;
    unique case (k)
      3'd0:    len = 3'd2;
      3'd4:    len = 3'd4;
      3'd6:    len = 3'd4;
      default: len = 3'd3;
    endcase
    return len;
  endfunction

  // Character at position pos of command word k; zero past the end.
  function automatic logic [ByteW-1:0] cmd_char(input logic [CodeW-1:0] k,
                                                input logic [WordPosW-1:0] pos);
    logic [4*ByteW-1:0] w;
    logic [ByteW-1:0]   c;
    w = '0;
    unique case (k)
      3'd0:    w = {"on", 16'h0000};
      3'd1:    w = {"off", 8'h00};
      3'd2:    w = {"low", 8'h00};
      3'd3:    w = {"mid", 8'h00};
      3'd4:    w = "high";
      3'd5:    w = {"pwm", 8'h00};
      3'd6:    w = "auto";
      default: w = '0;
    endcase
    c = pos[2] ? ChNul : w[{~pos[1:0], 3'b000} +: ByteW];
    return c;
  endfunction

endpackage

// File: rtl/tclp_front.sv
// Byte classifier: drops carriage returns and tags newlines as line ends.
module tclp_front import tclp_pkg::*; (
  input  logic             rx_valid_i,
  output logic             rx_ready_o,
  input  logic [ByteW-1:0] rx_byte_i,
  output logic             push_valid_o,
  input  logic             push_ready_i,
  output q_item_t          push_item_o
);

  // A carriage return is taken but never queued.
  assign rx_ready_o   = push_ready_i;
  assign push_valid_o = rx_valid_i && (rx_byte_i != ChCr);

  // Newline ends the line; every other byte is a character of it.
  always_comb begin
    push_item_o.data = rx_byte_i;
    push_item_o.op   = (rx_byte_i == ChLf) ? OpEnd : OpChar;
  end

endmodule

// File: rtl/tclp_queue.sv
// Short first-in first-out queue between the classifier and the interpreter.
module tclp_queue import tclp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_valid_i,
  output logic    push_ready_o,
  input  q_item_t push_item_i,
  output logic    pop_valid_o,
  input  logic    pop_ready_i,
  output q_item_t pop_item_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  q_item_t             mem_q [QueueDepth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                push, pop;

  assign push_ready_o = (count_q != CntW'(QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage needs no reset; only occupied slots are read.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// File: rtl/tclp_back.sv
// Line interpreter: parses each character as it arrives and acts on the line end.
module tclp_back import tclp_pkg::*; #(
  parameter int unsigned LINE_BYTES = LineBytesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_addr_i,
  input  logic [LevelW-1:0]  cfg_wdata_i,
  input  logic               pop_valid_i,
  output logic               pop_ready_o,
  input  q_item_t            pop_item_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output logic [CodeW-1:0]   command_code_o,
  output logic               fan_enable_o,
  output logic [LevelW-1:0]  fan_level_o,
  output logic               fan_mode_o
);

  localparam int unsigned FillW = $clog2(LINE_BYTES);

  // Level registers.
  logic [LevelW-1:0] low_level_q, mid_level_q, high_level_q;

  // Parse state of the current line.
  logic [FillW-1:0]    fill_q, fill_d;
  logic                ended_q, ended_d;
  phase_e              phase_q, phase_d;
  logic [NumCmds-1:0]  match_q, match_d;
  logic [WordPosW-1:0] wpos_q, wpos_d;
  logic                arg_seen_q, arg_seen_d;
  logic                digits_ok_q, digits_ok_d;
  logic [ArgW-1:0]     arg_q, arg_d;

  // Kept fan state and the result register.
  logic                fan_en_q, fan_en_d;
  logic [LevelW-1:0]   fan_lvl_q, fan_lvl_d;
  logic                fan_mode_q, fan_mode_d;
  logic                res_valid_q, res_valid_d;
  cmd_e                res_code_q, code;
  logic                res_en_q, res_mode_q;
  logic [LevelW-1:0]   res_lvl_q;

  logic                pop, is_char, is_end, overflow, live;
  logic [ByteW-1:0]    c;
  logic                is_digit;
  logic [ProdW-1:0]    prod;
  logic [LevelW-1:0]   pwm_level;

  // A line end waits for a free result slot; characters always go through.
  assign pop_ready_o = (pop_item_i.op == OpChar) || !res_valid_q || res_ready_i;
  assign pop         = pop_valid_i && pop_ready_o;
  assign is_char     = pop && (pop_item_i.op == OpChar);
  assign is_end      = pop && (pop_item_i.op == OpEnd);
  assign overflow    = (fill_q == FillW'(LINE_BYTES - 1));
  assign live        = is_char && !overflow && !ended_q && (pop_item_i.data != ChNul);

  // Fold to lower case and spot decimal digits.
  always_comb begin
    c = pop_item_i.data;
    if (c >= ChUpA && c <= ChUpZ) begin
      c = c | CaseBit;
    end
    is_digit = (c >= ChZero) && (c <= ChNine);
    prod = (ProdW'(arg_q) << 3) + (ProdW'(arg_q) << 1) + ProdW'(c - ChZero);
  end

  // Phase next state.
  always_comb begin
    phase_d = phase_q;
    if (is_end || (is_char && overflow)) begin
      phase_d = PhWord;
    end else if (live) begin
      unique case (phase_q)
        PhWord:   if (c == ChSpace) phase_d = PhSpaces;
        PhSpaces: if (c != ChSpace) phase_d = PhArg;
        PhArg:    phase_d = PhArg;
        default:  phase_d = PhWord;
      endcase
    end
  end

  // Per-character updates of the word match and the argument value.
  always_comb begin
    fill_d      = fill_q;
    ended_d     = ended_q;
    match_d     = match_q;
    wpos_d      = wpos_q;
    arg_seen_d  = arg_seen_q;
    digits_ok_d = digits_ok_q;
    arg_d       = arg_q;
    if (is_end || (is_char && overflow)) begin
      fill_d      = '0;
      ended_d     = 1'b0;
      match_d     = '1;
      wpos_d      = '0;
      arg_seen_d  = 1'b0;
      digits_ok_d = 1'b1;
      arg_d       = '0;
    end else if (is_char) begin
      fill_d = fill_q + 1'b1;
      if (!ended_q && pop_item_i.data == ChNul) begin
        ended_d = 1'b1;
      end
      if (live && phase_q == PhWord && c != ChSpace) begin
        for (int k = 0; k < NumCmds; k++) begin
          match_d[k] = match_q[k] && (wpos_q < cmd_len(CodeW'(k)))
                       && (c == cmd_char(CodeW'(k), wpos_q));
        end
        wpos_d = (wpos_q == '1) ? wpos_q : wpos_q + 1'b1;
      end
      if (live && (phase_q == PhArg || (phase_q == PhSpaces && c != ChSpace))) begin
        arg_seen_d = 1'b1;
        if (digits_ok_q) begin
          if (!is_digit) begin
            digits_ok_d = 1'b0;
          end else if (prod > ProdW'(PwmLimit)) begin
            arg_d = ArgW'(PwmLimit + 1);
          end else begin
            arg_d = prod[ArgW-1:0];
          end
        end
      end
    end
  end

  // Command decode at the line end: lowest matching word wins.
  always_comb begin
    code = CmdNone;
    for (int k = NumCmds - 1; k >= 0; k--) begin
      if (match_q[k] && wpos_q == cmd_len(CodeW'(k))) begin
        code = cmd_e'(CodeW'(k + 1));
      end
    end
    pwm_level = (arg_seen_q && digits_ok_q && arg_q != '0
                 && arg_q <= ArgW'(PwmLimit)) ? LevelW'(arg_q) : '0;
  end

  // Fan state after the command.
  always_comb begin
    fan_en_d   = fan_en_q;
    fan_lvl_d  = fan_lvl_q;
    fan_mode_d = fan_mode_q;
    if (is_end) begin
      unique case (code)
        CmdOn:   begin fan_en_d = 1'b1; fan_lvl_d = low_level_q;  fan_mode_d = 1'b0; end
        CmdOff:  begin fan_en_d = 1'b0; fan_lvl_d = low_level_q;  fan_mode_d = 1'b0; end
        CmdLow:  begin fan_en_d = 1'b1; fan_lvl_d = low_level_q;  fan_mode_d = 1'b0; end
        CmdMid:  begin fan_en_d = 1'b1; fan_lvl_d = mid_level_q;  fan_mode_d = 1'b0; end
        CmdHigh: begin fan_en_d = 1'b1; fan_lvl_d = high_level_q; fan_mode_d = 1'b0; end
        CmdPwm:  begin fan_en_d = 1'b1; fan_lvl_d = pwm_level;    fan_mode_d = 1'b0; end
        CmdAuto: begin fan_en_d = 1'b0; fan_lvl_d = low_level_q;  fan_mode_d = 1'b1; end
        default: begin end
      endcase
    end
  end

  // Result slot holds until taken.
  always_comb begin
    res_valid_d = res_valid_q;
    if (is_end) begin
      res_valid_d = 1'b1;
    end else if (res_ready_i) begin
      res_valid_d = 1'b0;
    end
  end

  // Control and kept state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q       <= '0;
      ended_q      <= 1'b0;
      phase_q      <= PhWord;
      match_q      <= '1;
      wpos_q       <= '0;
      arg_seen_q   <= 1'b0;
      digits_ok_q  <= 1'b1;
      arg_q        <= '0;
      fan_en_q     <= 1'b0;
      fan_lvl_q    <= '0;
      fan_mode_q   <= 1'b0;
      res_valid_q  <= 1'b0;
      low_level_q  <= LowLevelRst;
      mid_level_q  <= MidLevelRst;
      high_level_q <= HighLevelRst;
    end else begin
      fill_q      <= fill_d;
      ended_q     <= ended_d;
      phase_q     <= phase_d;
      match_q     <= match_d;
      wpos_q      <= wpos_d;
      arg_seen_q  <= arg_seen_d;
      digits_ok_q <= digits_ok_d;
      arg_q       <= arg_d;
      fan_en_q    <= fan_en_d;
      fan_lvl_q   <= fan_lvl_d;
      fan_mode_q  <= fan_mode_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CfgLowLevel:  low_level_q  <= cfg_wdata_i;
          CfgMidLevel:  mid_level_q  <= cfg_wdata_i;
          CfgHighLevel: high_level_q <= cfg_wdata_i;
          default:      begin end
        endcase
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (is_end) begin
      res_code_q <= code;
      res_en_q   <= fan_en_d;
      res_lvl_q  <= fan_lvl_d;
      res_mode_q <= fan_mode_d;
    end
  end

  assign res_valid_o    = res_valid_q;
  assign command_code_o = res_code_q;
  assign fan_enable_o   = res_en_q;
  assign fan_level_o    = res_lvl_q;
  assign fan_mode_o     = res_mode_q;

endmodule

// File: rtl/text_command_line_parser.sv
// Top level of the text command line parser.
//
//   Channel  Direction  Handshake               Beat contents
//   rx       in         rx_valid_i/rx_ready_o   rx_byte_i
//   res      out        res_valid_o/res_ready_i command_code_o, fan_enable_o,
//                                               fan_level_o, fan_mode_o
//   cfg      in         cfg_we_i                cfg_addr_i, cfg_wdata_i
//
// One byte is taken per cycle while the queue has room; the interpreter
// parses each character as it leaves the two-beat queue, so a newline
// needs no walk over the line, and its result is held in a register.
// A newline leaves the queue only once the result register is free.
// Reset clears the line, the fan state and the level registers to defaults.
module text_command_line_parser import tclp_pkg::*; #(
  parameter int unsigned LINE_BYTES = LineBytesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_addr_i,
  input  logic [LevelW-1:0]  cfg_wdata_i,
  input  logic               rx_valid_i,
  output logic               rx_ready_o,
  input  logic [ByteW-1:0]   rx_byte_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output logic [CodeW-1:0]   command_code_o,
  output logic               fan_enable_o,
  output logic [LevelW-1:0]  fan_level_o,
  output logic               fan_mode_o
);

  logic    push_valid, push_ready, pop_valid, pop_ready;
  q_item_t push_item, pop_item;

  // Classifier.
  tclp_front u_front (
    .rx_valid_i   (rx_valid_i),
    .rx_ready_o   (rx_ready_o),
    .rx_byte_i    (rx_byte_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  // Queue between the two halves.
  tclp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  // Interpreter.
  tclp_back #(
    .LINE_BYTES (LINE_BYTES)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .pop_valid_i    (pop_valid),
    .pop_ready_o    (pop_ready),
    .pop_item_i     (pop_item),
    .res_valid_o    (res_valid_o),
    .res_ready_i    (res_ready_i),
    .command_code_o (command_code_o),
    .fan_enable_o   (fan_enable_o),
    .fan_level_o    (fan_level_o),
    .fan_mode_o     (fan_mode_o)
  );

endmodule

// File: rtl/tclp_checker.sv
// Port-level checks of the text command line parser and their binding.
module tclp_checker import tclp_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               res_valid_o,
  input logic               res_ready_i,
  input logic [CodeW-1:0]   command_code_o,
  input logic               fan_enable_o,
  input logic [LevelW-1:0]  fan_level_o,
  input logic               fan_mode_o
);

  // A result beat holds until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_ready_i |=> res_valid_o && $stable(fan_level_o)
                                    && $stable(command_code_o))
    else $error("result beat changed before it was taken");

  // Automatic mode stops the fan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && command_code_o == CmdAuto |-> fan_mode_o && !fan_enable_o)
    else $error("auto command must give automatic mode with the fan stopped");

  // Running commands select manual mode with the fan enabled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (command_code_o == CmdOn || command_code_o == CmdLow
                    || command_code_o == CmdMid || command_code_o == CmdHigh
                    || command_code_o == CmdPwm)
    |-> fan_enable_o && !fan_mode_o)
    else $error("running command must enable the fan in manual mode");

  // A pwm level never exceeds the limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && command_code_o == CmdPwm |-> fan_level_o <= LevelW'(PwmLimit))
    else $error("pwm level above the limit");

endmodule

bind text_command_line_parser tclp_checker u_checker (.*);
